// ----- hw/rtl/unrd_pkg.sv -----
package unrd_pkg;

    localparam int WIDTH   = 32;
    localparam int FIELD_W = 32;
    localparam int OPND_W  = (WIDTH > FIELD_W) ? WIDTH : FIELD_W;

    typedef struct packed {
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
    } req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] quotient;
        logic [FIELD_W-1:0] remainder;
    } res_t;

    // partial remainder is signed, one bit wider than the operands
    typedef struct packed {
        logic [WIDTH:0]   a;
        logic [WIDTH-1:0] q;
        logic [WIDTH-1:0] m;
    } stage_t;

endpackage

// ----- hw/rtl/unrd_cell.sv -----
module unrd_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  unrd_pkg::stage_t stg_in,
    output logic            vld_out,
    output unrd_pkg::stage_t stg_out
);
    import unrd_pkg::*;

    logic             vld_reg;
    stage_t           stg_reg;
    stage_t           stg_next;
    logic [WIDTH:0]   a_sh;
    logic [WIDTH:0]   m_ext;

    always_comb
    begin
        a_sh  = {stg_in.a[WIDTH-1:0], stg_in.q[WIDTH-1]};
        m_ext = {1'b0, stg_in.m};
        stg_next.m = stg_in.m;
        if (stg_in.a[WIDTH])
        begin
            stg_next.a = a_sh + m_ext;
        end
        else
        begin
            stg_next.a = a_sh - m_ext;
        end
        stg_next.q = {stg_in.q[WIDTH-2:0], ~stg_next.a[WIDTH]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg <= stg_next;
        end
    end

    assign vld_out = vld_reg;
    assign stg_out = stg_reg;

endmodule

// ----- hw/rtl/unrd_fix.sv -----
module unrd_fix (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  unrd_pkg::stage_t stg_in,
    output logic             vld_out,
    output unrd_pkg::res_t   res_out
);
    import unrd_pkg::*;

    logic              vld_reg;
    res_t              res_reg;
    res_t              res_next;
    logic [WIDTH-1:0]  rem;
    logic [OPND_W-1:0] q_ext;
    logic [OPND_W-1:0] r_ext;

    always_comb
    begin
        // negative partial remainder gets the divisor added back
        if (stg_in.a[WIDTH])
        begin
            rem = stg_in.a[WIDTH-1:0] + stg_in.m;
        end
        else
        begin
            rem = stg_in.a[WIDTH-1:0];
        end
        q_ext = OPND_W'(stg_in.q);
        r_ext = OPND_W'(rem);
        if (stg_in.m == '0)
        begin
            res_next.quotient  = '0;
            res_next.remainder = '0;
        end
        else
        begin
            res_next.quotient  = q_ext[FIELD_W-1:0];
            res_next.remainder = r_ext[FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign vld_out = vld_reg;
    assign res_out = res_reg;

endmodule

// ----- hw/rtl/unsigned_nonrestoring_divider.sv -----
// channel | valid     | stall     | payload
// --------+-----------+-----------+--------------------------------
// in      | req_valid | req_stall | req (dividend, divisor)
// out     | res_valid | res_stall | res (quotient, remainder)
//
// One request per cycle unless req_stall is high; each request passes through one cell per
// quotient bit, then the correction/output register, before its result is valid.
// Reset empties the pipeline; no clearing pass.
// A stalled result freezes the whole cell chain, and req_stall follows.
module unsigned_nonrestoring_divider (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  unrd_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_stall,
    output unrd_pkg::res_t res
);
    import unrd_pkg::*;

    logic              adv;
    logic [OPND_W-1:0] dvd_ext;
    logic [OPND_W-1:0] dvs_ext;
    logic [WIDTH:0]    vld;
    stage_t            stg [WIDTH+1];

    assign adv       = !(res_valid && res_stall);
    assign req_stall = !adv;

    assign dvd_ext   = OPND_W'(req.dividend);
    assign dvs_ext   = OPND_W'(req.divisor);
    assign vld[0]    = req_valid;
    assign stg[0].a  = '0;
    assign stg[0].q  = dvd_ext[WIDTH-1:0];
    assign stg[0].m  = dvs_ext[WIDTH-1:0];

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        unrd_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .vld_in  (vld[i]),
            .stg_in  (stg[i]),
            .vld_out (vld[i+1]),
            .stg_out (stg[i+1])
        );
    end

    unrd_fix u_fix (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (vld[WIDTH]),
        .stg_in  (stg[WIDTH]),
        .vld_out (res_valid),
        .res_out (res)
    );

endmodule

// ----- hw/rtl/unrd_check.sv -----
module unrd_check (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input unrd_pkg::req_t req,
    input logic           res_valid,
    input logic           res_stall,
    input unrd_pkg::res_t res
);
    import unrd_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res))
        else $error("stalled result changed");

    a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |-> req_stall)
        else $error("request taken while result blocked");

    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !req_stall)
        else $error("request stalled with empty output");

endmodule

bind unsigned_nonrestoring_divider unrd_check u_check (.*);
